@@ src/fpk_pkg.sv @@
// shared types, constants and helper functions of the meter protocol frame packer
`default_nettype none

package fpk_pkg;

    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned CFG_ADDR_W  = 5;
    localparam int unsigned ADDR_W      = 40;
    localparam int unsigned COUNT_W     = 12;
    localparam int unsigned IDX_W       = 4;

    localparam logic [7:0]  START_BYTE  = 8'h68;
    localparam logic [7:0]  END_BYTE    = 8'h16;
    localparam logic [7:0]  SEQ_BASE    = 8'h60;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 12'hfff;
    localparam logic [COUNT_W-1:0] FRAME_OVERHEAD = 12'd8;
    localparam logic [COUNT_W-1:0] UNIT_ID_BYTES  = 12'd4;

    localparam logic [7:0]        CONTROL_RESET  = 8'h4b;
    localparam logic [ADDR_W-1:0] ADDRESS_RESET  = 40'h04_0001_2500;
    localparam logic [1:0]        PROTOCOL_RESET = 2'd2;

    localparam logic [1:0] REG_CONTROL  = 2'd0;
    localparam logic [1:0] REG_ADDRESS  = 2'd1;
    localparam logic [1:0] REG_PROTOCOL = 2'd2;

    localparam logic [IDX_W-1:0] HEADER_LAST_IDX = 4'd13;
    localparam logic [IDX_W-1:0] UNIT_LAST_IDX   = 4'd3;
    localparam logic [IDX_W-1:0] DATA_LAST_IDX   = 4'd0;
    localparam logic [IDX_W-1:0] END_LAST_IDX    = 4'd1;
    localparam logic [IDX_W-1:0] HEADER_SUM_IDX  = 4'd6;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_UNIT   = 2'd1,
        KIND_DATA   = 2'd2,
        KIND_END    = 2'd3
    } kind_t;

    // header: len lo, len hi, afn, seq; unit: four id bytes; data: byte 0
    typedef struct packed {
        kind_t           kind;
        logic [3:0][7:0] bytes;
        logic            mismatch;
    } cmd_t;

    function automatic logic [7:0] bcd_byte(input logic [7:0] v);
        logic [6:0]  t;
        logic [13:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        begin
            if (v >= 8'd200)
            begin
                t = 7'(v - 8'd200);
            end
            else if (v >= 8'd100)
            begin
                t = 7'(v - 8'd100);
            end
            else
            begin
                t = v[6:0];
            end
            prod  = 14'(t) * 14'd103;
            tens  = prod[13:10];
            units = t - 7'(tens) * 7'd10;
            return {tens, units[3:0]};
        end
    endfunction

    function automatic logic [7:0] bit_byte(input logic [2:0] pos);
        begin
            return 8'd1 << pos;
        end
    endfunction

endpackage

`default_nettype wire

@@ src/fpk_front.sv @@
// front end: accepts requests, keeps frame counters and encodes each request
`default_nettype none

module fpk_front
    import fpk_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [1:0]          kind,
    input  wire logic [7:0]          afn,
    input  wire logic [COUNT_W-1:0]  declared_unit_bytes,
    input  wire logic [10:0]         point_number,
    input  wire logic [7:0]          function_number,
    input  wire logic [7:0]          data_value,
    input  wire logic                use_raw,
    input  wire logic [1:0]          protocol_id,
    output cmd_t                     cmd
);

    logic [3:0]         seq_reg, seq_next;
    logic [COUNT_W-1:0] unit_count_reg, unit_count_next;
    logic [COUNT_W-1:0] declared_reg, declared_next;

    kind_t              kind_in;
    logic [13:0]        len_units;
    logic [15:0]        len;
    logic [10:0]        p_m1;
    logic [7:0]         f_m1;
    logic [COUNT_W:0]   count_sum;
    logic [COUNT_W-1:0] count_add;
    logic [COUNT_W-1:0] count_sat;

    assign kind_in   = kind_t'(kind);
    assign len_units = 14'(declared_unit_bytes) + 14'(FRAME_OVERHEAD);
    assign len       = {len_units, protocol_id};
    assign p_m1      = point_number - 11'd1;
    assign f_m1      = function_number - 8'd1;
    assign count_add = (kind_in == KIND_UNIT) ? UNIT_ID_BYTES : 12'd1;
    assign count_sum = {1'b0, unit_count_reg} + {1'b0, count_add};
    assign count_sat = count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];

    always_comb
    begin
        seq_next        = seq_reg;
        unit_count_next = unit_count_reg;
        declared_next   = declared_reg;
        cmd.kind        = kind_in;
        cmd.bytes       = '0;
        cmd.mismatch    = 1'b0;
        case (kind_in)
            KIND_HEADER:
            begin
                seq_next        = seq_reg + 4'd1;
                unit_count_next = '0;
                declared_next   = declared_unit_bytes;
                cmd.bytes[0]    = len[7:0];
                cmd.bytes[1]    = len[15:8];
                cmd.bytes[2]    = afn;
                cmd.bytes[3]    = SEQ_BASE | {4'd0, seq_next};
            end
            KIND_UNIT:
            begin
                unit_count_next = count_sat;
                if (point_number != 11'd0)
                begin
                    cmd.bytes[0] = bit_byte(p_m1[2:0]);
                    cmd.bytes[1] = p_m1[10:3] + 8'd1;
                end
                if (function_number != 8'd0)
                begin
                    cmd.bytes[2] = bit_byte(f_m1[2:0]);
                    cmd.bytes[3] = {3'd0, f_m1[7:3]};
                end
            end
            KIND_DATA:
            begin
                unit_count_next = count_sat;
                cmd.bytes[0]    = use_raw ? data_value : bcd_byte(data_value);
            end
            KIND_END:
            begin
                cmd.mismatch = (unit_count_reg != declared_reg);
            end
            default:
            begin
                cmd.kind = KIND_END;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg        <= '0;
            unit_count_reg <= '0;
            declared_reg   <= '0;
        end
        else if (accept)
        begin
            seq_reg        <= seq_next;
            unit_count_reg <= unit_count_next;
            declared_reg   <= declared_next;
        end
    end

endmodule

`default_nettype wire

@@ src/fpk_queue.sv @@
// two-entry request queue between front end and byte sequencer
`default_nettype none

module fpk_queue
    import fpk_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  cmd_t      wr_data,
    output logic      full,
    input  wire logic rd_en,
    output cmd_t      rd_data,
    output logic      rd_valid
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (!wr_en && rd_en)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/fpk_back.sv @@
// byte sequencer: expands queued requests into frame bytes and keeps the checksum
`default_nettype none

module fpk_back
    import fpk_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    input  cmd_t                   cmd,
    output logic                   cmd_pop,
    input  wire logic [7:0]        control_code,
    input  wire logic [ADDR_W-1:0] station_address,
    output logic                   empty,
    input  wire logic              pop,
    output logic [7:0]             out_byte,
    output logic                   last,
    output logic                   length_mismatch
);

    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             last_reg;
    logic             mismatch_reg;
    logic [7:0]       sum_reg, sum_next;
    logic [IDX_W-1:0] idx_reg;

    logic             advance;
    logic [IDX_W-1:0] last_idx;
    logic [7:0]       byte_sel;
    logic             summed;
    logic             is_end_byte;

    assign empty           = !out_valid_reg;
    assign out_byte        = out_byte_reg;
    assign last            = last_reg;
    assign length_mismatch = mismatch_reg;

    assign advance = cmd_valid && (!out_valid_reg || pop);
    assign cmd_pop = advance && (idx_reg == last_idx);

    always_comb
    begin
        last_idx    = DATA_LAST_IDX;
        byte_sel    = cmd.bytes[0];
        summed      = 1'b1;
        is_end_byte = 1'b0;
        sum_next    = sum_reg;
        case (cmd.kind)
            KIND_HEADER:
            begin
                last_idx = HEADER_LAST_IDX;
                summed   = (idx_reg >= HEADER_SUM_IDX);
                case (idx_reg)
                    4'd0:    byte_sel = START_BYTE;
                    4'd1:    byte_sel = cmd.bytes[0];
                    4'd2:    byte_sel = cmd.bytes[1];
                    4'd3:    byte_sel = cmd.bytes[0];
                    4'd4:    byte_sel = cmd.bytes[1];
                    4'd5:    byte_sel = START_BYTE;
                    4'd6:    byte_sel = control_code;
                    4'd7:    byte_sel = station_address[7:0];
                    4'd8:    byte_sel = station_address[15:8];
                    4'd9:    byte_sel = station_address[23:16];
                    4'd10:   byte_sel = station_address[31:24];
                    4'd11:   byte_sel = station_address[39:32];
                    4'd12:   byte_sel = cmd.bytes[2];
                    default: byte_sel = cmd.bytes[3];
                endcase
            end
            KIND_UNIT:
            begin
                last_idx = UNIT_LAST_IDX;
                byte_sel = cmd.bytes[idx_reg[1:0]];
            end
            KIND_DATA:
            begin
                last_idx = DATA_LAST_IDX;
            end
            default:
            begin
                last_idx    = END_LAST_IDX;
                summed      = 1'b0;
                is_end_byte = (idx_reg == END_LAST_IDX);
                byte_sel    = is_end_byte ? END_BYTE : sum_reg;
            end
        endcase
        if (cmd.kind == KIND_HEADER && idx_reg == '0)
        begin
            sum_next = '0;
        end
        else if (summed)
        begin
            sum_next = sum_reg + byte_sel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= byte_sel;
            last_reg     <= is_end_byte;
            mismatch_reg <= is_end_byte && cmd.mismatch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                sum_reg       <= sum_next;
                idx_reg       <= cmd_pop ? '0 : idx_reg + 4'd1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/meter_protocol_frame_packer.sv @@
// top level of the meter protocol frame packer with its configuration registers
//
// requests enter through push/full: header, unit identifier, data byte or end.
// frame bytes leave through empty/pop, one byte per pop on the result side,
// oldest first; last marks the closing 0x16 byte and length_mismatch on that
// byte reports a unit byte count that differs from the header's declared count.
// a request accepted into an idle block passes through the queue entry and
// then the output byte register before its first byte shows.
// the byte sequencer sends one byte per cycle unless the receiver stalls; a header
// gives 14 bytes, a unit identifier 4, a data byte 1 and an end request 2; a
// two-entry queue lets the front end take requests while the sequencer is busy.
// a stalled receiver holds the current byte; the queue then fills and full rises.
// registers (64-bit apb, byte address 8*i): control code, station address,
// protocol id; write them only while no frame bytes are pending.
// reset clears the sequence counter, checksum and counts, restores register
// defaults and leaves the result side empty.
`default_nettype none

module meter_protocol_frame_packer
    import fpk_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [1:0]            kind,
    input  wire logic [7:0]            afn,
    input  wire logic [COUNT_W-1:0]    declared_unit_bytes,
    input  wire logic [10:0]           point_number,
    input  wire logic [7:0]            function_number,
    input  wire logic [7:0]            data_value,
    input  wire logic                  use_raw,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [7:0]                 out_byte,
    output logic                       last,
    output logic                       length_mismatch,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic [7:0]        control_code_reg;
    logic [ADDR_W-1:0] station_address_reg;
    logic [1:0]        protocol_id_reg;

    logic              cfg_write;
    logic [1:0]        reg_index;
    logic              accept;
    cmd_t              front_cmd;
    cmd_t              queue_cmd;
    logic              queue_valid;
    logic              queue_pop;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[4:3];
    assign accept    = push && !full;

    always_comb
    begin
        case (reg_index)
            REG_CONTROL:  prdata = {56'd0, control_code_reg};
            REG_ADDRESS:  prdata = {24'd0, station_address_reg};
            REG_PROTOCOL: prdata = {62'd0, protocol_id_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_code_reg    <= CONTROL_RESET;
            station_address_reg <= ADDRESS_RESET;
            protocol_id_reg     <= PROTOCOL_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_CONTROL:  control_code_reg    <= pwdata[7:0];
                REG_ADDRESS:  station_address_reg <= pwdata[ADDR_W-1:0];
                REG_PROTOCOL: protocol_id_reg     <= pwdata[1:0];
                default:      ;
            endcase
        end
    end

    fpk_front u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .accept              (accept),
        .kind                (kind),
        .afn                 (afn),
        .declared_unit_bytes (declared_unit_bytes),
        .point_number        (point_number),
        .function_number     (function_number),
        .data_value          (data_value),
        .use_raw             (use_raw),
        .protocol_id         (protocol_id_reg),
        .cmd                 (front_cmd)
    );

    fpk_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept),
        .wr_data  (front_cmd),
        .full     (full),
        .rd_en    (queue_pop),
        .rd_data  (queue_cmd),
        .rd_valid (queue_valid)
    );

    fpk_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (queue_valid),
        .cmd             (queue_cmd),
        .cmd_pop         (queue_pop),
        .control_code    (control_code_reg),
        .station_address (station_address_reg),
        .empty           (empty),
        .pop             (pop),
        .out_byte        (out_byte),
        .last            (last),
        .length_mismatch (length_mismatch)
    );

endmodule

`default_nettype wire
